// ===== rtl/piecewise_hermite_curve_interpolator_assert.svh =====
// Assertion macros shared by the curve interpolator RTL.
// No dependencies; the checks compile away when SYNTHESIS is defined.
`ifndef PIECEWISE_HERMITE_CURVE_INTERPOLATOR_ASSERT_SVH
`define PIECEWISE_HERMITE_CURVE_INTERPOLATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define PHCI_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define PHCI_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define PHCI_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define PHCI_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ===== rtl/phci_pkg.sv =====
// Types, constants and helpers for the curve interpolator.
// No dependencies.
package phci_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int T_BITS     = 30;
  localparam int MAX_KNOTS  = 64;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;
  localparam int DIV_W      = 48;
  localparam int DVS_W      = 17;
  localparam int MUL_W      = 34;
  localparam int PROD_W     = 68;
  localparam int SLOPE_SH   = 15;
  localparam int MODE_HOLD  = 0;
  localparam int MODE_LIN   = 1;

  // Division by 15: the upper 24 bits are scaled by (2^24 - 1) / 15, and the
  // sum of both halves is divided by a reciprocal multiply, ceil(2^29 / 15).
  localparam int          SLOPE_LO_W   = 24;
  localparam logic [20:0] SLOPE_HI_MUL = 21'h111111;
  localparam logic [25:0] SLOPE_RCP    = 26'd35791395;
  localparam int          SLOPE_RCP_SH = 29;

  localparam logic [0:0] KIND_LOAD  = 1'b0;
  localparam logic [0:0] KIND_QUERY = 1'b1;

  typedef struct packed {
    logic signed [15:0] pos;
    logic signed [31:0] val;
    logic [1:0]         mode;
    logic signed [15:0] in_slope;
    logic signed [15:0] out_slope;
  } knot_t;

  typedef struct packed {
    logic [0:0]         kind;
    logic [5:0]         knot_index;
    logic signed [15:0] knot_position;
    logic signed [31:0] knot_value;
    logic [1:0]         knot_mode;
    logic signed [15:0] left_slope;
    logic signed [15:0] right_slope;
    logic signed [31:0] query_position;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] curve_value;
    logic [5:0]         segment;
  } out_word_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -50'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/phci_stream_if.sv =====
// Valid/ready channel carrying one word of a given payload type.
// No dependencies.
interface phci_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, input ready, output data);
  modport sink (input valid, output ready, input data);
endinterface

// ===== rtl/piecewise_hermite_curve_interpolator.sv =====
// Piecewise cubic Hermite curve interpolator, top level.
// Uses phci_pkg, phci_stream_if, phci_knot_mem, phci_div and the assertion header.
//
// Usage: words on in_chan either load one knot (kind 0) or query the curve
// (kind 1). Loads give no result. A query gives one word
// on out_chan with the saturated Q16.16 curve value and the segment index.
// cfg_we/cfg_wdata set the number of knots in use; write it only while idle.
// A query either clamps to an end knot, or walks the knot table (one memory
// read per cycle) and then evaluates its segment: a hold segment directly,
// a linear segment with one serial division, and a cubic segment with one
// serial division, eight passes through the shared multiplier and two more
// for the slope scaling. One query is in flight at a time; in_chan.ready
// is high only while no query is in progress.
// The result sits in an output register, so a new word is accepted while it
// waits; a finished query waits until that register is free.
// Reset clears the control state and sets the knot count to one; the knot
// table is not cleared and must be loaded before use.
`include "piecewise_hermite_curve_interpolator_assert.svh"
module piecewise_hermite_curve_interpolator
  import phci_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  phci_stream_if.sink          in_chan,
  phci_stream_if.source        out_chan,
  input  logic                 cfg_we,
  input  logic [CNT_W-1:0]     cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE, S_FIRST, S_LAST, S_SCAN, S_EVAL, S_TDIV, S_LIN1, S_LIN2,
    S_TT, S_T2T, S_H, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7,
    S_SL, S_Q1, S_Q2, S_Q3, S_Q4, S_OUT
  } state_t;

  localparam logic signed [PROD_W-1:0] RND_T   = PROD_W'(64'sd1 <<< (T_BITS - 1));
  localparam logic signed [PROD_W-1:0] RND_SL  = PROD_W'(64'sd245760);
  localparam logic signed [32:0]       T_ONE   = 33'sd1 <<< T_BITS;

  state_t                    state_r;
  logic [CNT_W-1:0]          knots_r;
  logic                      out_valid_r;
  out_word_t                 out_data_r;
  logic signed [31:0]        x_r;
  knot_t                     left_r;
  knot_t                     right_r;
  logic [IDX_W-1:0]          k_r;
  logic [IDX_W-1:0]          seg_r;
  logic signed [31:0]        res_r;
  logic [T_BITS-1:0]         t_r;
  logic [T_BITS-1:0]         t2_r;
  logic signed [31:0]        h00_r, h01_r, h10_r, h11_r;
  logic signed [PROD_W-1:0]  acc_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [37:0]        base_r;
  logic signed [MUL_W-1:0]   sd0_r, sd1_r;
  logic                      neg_r;
  logic [DIV_W-1:0]          nd_r;
  logic [DIV_W-1:0]          qh_r;
  logic [DIV_W-1:0]          quo_r;

  logic [CNT_W-1:0]          n_clamp;
  logic [IDX_W-1:0]          nlast;
  logic                      in_acc;
  logic                      mem_we;
  knot_t                     mem_wdata;
  logic [IDX_W-1:0]          mem_raddr;
  knot_t                     mem_rdata;
  logic signed [31:0]        posq;
  logic signed [16:0]        diff;
  logic [32:0]               d_w;
  logic                      div_start;
  logic                      div_done;
  logic [DIV_W-1:0]          div_dvd;
  logic [DVS_W-1:0]          div_dvs;
  logic [DIV_W-1:0]          div_quo;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic [T_BITS-1:0]         t_hi;
  logic signed [32:0]        t_e, t2_e, t3_e;
  logic signed [32:0]        h00_w, h01_w, h10_w, h11_w;
  logic signed [PROD_W-1:0]  lin_term, base_term, sx, sy;
  logic signed [32:0]        vdiff;
  logic signed [49:0]        lin_sum, cubic_sum;
  logic signed [48:0]        slope49;
  logic [DIV_W-1:0]          slope_dvd;
  logic [SLOPE_LO_W:0]       nsum;
  logic [DIV_W-1:0]          q_lo;

  assign n_clamp = (knots_r == '0) ? CNT_W'(1) :
                   (knots_r > CNT_W'(MAX_KNOTS)) ? CNT_W'(MAX_KNOTS) : knots_r;
  assign nlast   = IDX_W'(n_clamp - 1'b1);

  assign in_chan.ready  = (state_r == S_IDLE);
  assign in_acc         = in_chan.valid && (state_r == S_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  assign mem_we              = in_acc && (in_chan.data.kind == KIND_LOAD);
  assign mem_wdata.pos       = in_chan.data.knot_position;
  assign mem_wdata.val       = in_chan.data.knot_value;
  assign mem_wdata.mode      = in_chan.data.knot_mode;
  assign mem_wdata.in_slope  = in_chan.data.left_slope;
  assign mem_wdata.out_slope = in_chan.data.right_slope;

  always_comb begin
    case (state_r)
      S_FIRST: mem_raddr = nlast;
      S_LAST:  mem_raddr = IDX_W'(1);
      S_SCAN:  mem_raddr = k_r + 1'b1;
      default: mem_raddr = '0;
    endcase
  end

  phci_knot_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (in_chan.data.knot_index),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign posq = signed'({mem_rdata.pos, {FRAC_BITS{1'b0}}});
  assign diff = {right_r.pos[15], right_r.pos} - {left_r.pos[15], left_r.pos};
  assign d_w  = {x_r[31], x_r} - {left_r.pos[15], left_r.pos, {FRAC_BITS{1'b0}}};

  assign sx        = acc_r + RND_SL;
  assign sy        = sx >>> SLOPE_SH;
  assign slope_dvd = sx[PROD_W-1] ? ~sy[DIV_W-1:0] : sy[DIV_W-1:0];

  assign nsum = {1'b0, nd_r[DIV_W-1:SLOPE_LO_W]} + {1'b0, nd_r[SLOPE_LO_W-1:0]};
  assign q_lo = {{(DIV_W-22){1'b0}}, prod_r[SLOPE_RCP_SH+21:SLOPE_RCP_SH]};

  assign div_start = (state_r == S_EVAL) && !left_r.mode[MODE_HOLD];
  assign div_dvd   = {2'b00, d_w[31:0], {(T_BITS - FRAC_BITS){1'b0}}};
  assign div_dvs   = unsigned'(diff);

  phci_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign vdiff = {right_r.val[31], right_r.val} - {left_r.val[31], left_r.val};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_LIN1: begin
        mul_a = {vdiff[32], vdiff};
        mul_b = {4'b0000, t_r};
      end
      S_TT: begin
        mul_a = {4'b0000, t_r};
        mul_b = {4'b0000, t_r};
      end
      S_T2T: begin
        mul_a = {4'b0000, t_hi};
        mul_b = {4'b0000, t_r};
      end
      S_M1: begin
        mul_a = {{2{h00_r[31]}}, h00_r};
        mul_b = {{2{left_r.val[31]}}, left_r.val};
      end
      S_M2: begin
        mul_a = {{2{h01_r[31]}}, h01_r};
        mul_b = {{2{right_r.val[31]}}, right_r.val};
      end
      S_M3: begin
        mul_a = {{18{left_r.out_slope[15]}}, left_r.out_slope};
        mul_b = {{17{diff[16]}}, diff};
      end
      S_M4: begin
        mul_a = {{18{right_r.in_slope[15]}}, right_r.in_slope};
        mul_b = {{17{diff[16]}}, diff};
      end
      S_M5: begin
        mul_a = {{2{h10_r[31]}}, h10_r};
        mul_b = sd0_r;
      end
      S_M6: begin
        mul_a = {{2{h11_r[31]}}, h11_r};
        mul_b = sd1_r;
      end
      S_Q1: begin
        mul_a = {10'b0, nd_r[DIV_W-1:SLOPE_LO_W]};
        mul_b = {13'b0, SLOPE_HI_MUL};
      end
      S_Q2: begin
        mul_a = {9'b0, nsum};
        mul_b = {8'b0, SLOPE_RCP};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign t_hi  = prod_r[2*T_BITS-1:T_BITS];
  assign t_e   = {3'b000, t_r};
  assign t2_e  = {3'b000, t2_r};
  assign t3_e  = {3'b000, t_hi};
  assign h00_w = (t3_e <<< 1) - (t2_e + (t2_e <<< 1)) + T_ONE;
  assign h01_w = (t2_e + (t2_e <<< 1)) - (t3_e <<< 1);
  assign h10_w = t3_e - (t2_e <<< 1) + t_e;
  assign h11_w = t3_e - t2_e;

  assign lin_term  = (prod_r + RND_T) >>> T_BITS;
  assign base_term = (acc_r + RND_T) >>> T_BITS;
  assign lin_sum   = {{18{left_r.val[31]}}, left_r.val} +
                     {{12{lin_term[37]}}, lin_term[37:0]};
  assign slope49   = neg_r ? ~{1'b0, quo_r} : {1'b0, quo_r};
  assign cubic_sum = {{12{base_r[37]}}, base_r} + {slope49[48], slope49};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      knots_r     <= CNT_W'(1);
    end else begin
      prod_r <= mul_a * mul_b;
      if (cfg_we) begin
        knots_r <= cfg_wdata;
      end
      if (out_valid_r && out_chan.ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && (in_chan.data.kind == KIND_QUERY)) begin
            x_r     <= in_chan.data.query_position;
            state_r <= S_FIRST;
          end
        end
        S_FIRST: begin
          left_r <= mem_rdata;
          if (x_r <= posq) begin
            res_r   <= mem_rdata.val;
            seg_r   <= '0;
            state_r <= S_OUT;
          end else begin
            state_r <= S_LAST;
          end
        end
        S_LAST: begin
          if (x_r >= posq) begin
            res_r   <= mem_rdata.val;
            seg_r   <= nlast;
            state_r <= S_OUT;
          end else begin
            k_r     <= IDX_W'(1);
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (x_r < posq) begin
            right_r <= mem_rdata;
            seg_r   <= k_r - 1'b1;
            state_r <= S_EVAL;
          end else begin
            left_r <= mem_rdata;
            k_r    <= k_r + 1'b1;
          end
        end
        S_EVAL: begin
          if (left_r.mode[MODE_HOLD]) begin
            res_r   <= left_r.val;
            state_r <= S_OUT;
          end else begin
            state_r <= S_TDIV;
          end
        end
        S_TDIV: begin
          if (div_done) begin
            t_r     <= div_quo[T_BITS-1:0];
            state_r <= left_r.mode[MODE_LIN] ? S_LIN1 : S_TT;
          end
        end
        S_LIN1: state_r <= S_LIN2;
        S_LIN2: begin
          res_r   <= sat32(lin_sum);
          state_r <= S_OUT;
        end
        S_TT:  state_r <= S_T2T;
        S_T2T: begin
          t2_r    <= t_hi;
          state_r <= S_H;
        end
        S_H: begin
          h00_r   <= h00_w[31:0];
          h01_r   <= h01_w[31:0];
          h10_r   <= h10_w[31:0];
          h11_r   <= h11_w[31:0];
          state_r <= S_M1;
        end
        S_M1: state_r <= S_M2;
        S_M2: begin
          acc_r   <= prod_r;
          state_r <= S_M3;
        end
        S_M3: begin
          acc_r   <= acc_r + prod_r;
          state_r <= S_M4;
        end
        S_M4: begin
          base_r  <= base_term[37:0];
          sd0_r   <= prod_r[MUL_W-1:0];
          state_r <= S_M5;
        end
        S_M5: begin
          sd1_r   <= prod_r[MUL_W-1:0];
          state_r <= S_M6;
        end
        S_M6: begin
          acc_r   <= prod_r;
          state_r <= S_M7;
        end
        S_M7: begin
          acc_r   <= acc_r + prod_r;
          state_r <= S_SL;
        end
        S_SL: begin
          neg_r   <= sx[PROD_W-1];
          nd_r    <= slope_dvd;
          state_r <= S_Q1;
        end
        S_Q1: state_r <= S_Q2;
        S_Q2: begin
          qh_r    <= prod_r[DIV_W-1:0];
          state_r <= S_Q3;
        end
        S_Q3: begin
          quo_r   <= qh_r + q_lo;
          state_r <= S_Q4;
        end
        S_Q4: begin
          res_r   <= sat32(cubic_sum);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r            <= 1'b1;
            out_data_r.curve_value <= res_r;
            out_data_r.segment     <= seg_r;
            state_r                <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `PHCI_ASSERT_IMPL(a_load_when_idle, clk, rst_n, mem_we, state_r == S_IDLE)
  `PHCI_ASSERT_IMPL(a_div_done_waited, clk, rst_n, div_done, state_r == S_TDIV)
  `PHCI_ASSERT_NEXT(a_result_posted, clk, rst_n, state_r == S_OUT && (!out_valid_r || out_chan.ready), out_valid_r && state_r == S_IDLE)

endmodule

// ===== rtl/phci_knot_mem.sv =====
// Knot table: one write port and one read port with registered read data.
// Uses phci_pkg.
module phci_knot_mem
  import phci_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  knot_t            wdata,
  input  logic [IDX_W-1:0] raddr,
  output knot_t            rdata
);

  knot_t mem [MAX_KNOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/phci_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Uses phci_pkg.
module phci_div
  import phci_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CW = $clog2(DIV_W);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DIV_W-1:0] quo_r;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_W - 1);
        rem_r  <= '0;
        dvs_r  <= divisor;
        quo_r  <= dividend;
      end else if (busy_r) begin
        rem_r <= fits ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
